// ===== rtl/core/tnorm_pkg.sv =====
package tnorm_pkg;

  localparam int PUNCT_DEPTH = 16;
  localparam int PIDX_W = (PUNCT_DEPTH > 1) ? $clog2(PUNCT_DEPTH) : 1;
  localparam int PCNT_W = $clog2(PUNCT_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [7:0] LEAD_D0  = 8'hD0;
  localparam logic [7:0] LEAD_D1  = 8'hD1;
  localparam logic [7:0] CYR_LO   = 8'h90;
  localparam logic [7:0] CYR_MID  = 8'hA0;
  localparam logic [7:0] CYR_HI   = 8'hAF;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] LAT_A    = 8'h41;
  localparam logic [7:0] LAT_Z    = 8'h5A;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } tail_t;

  typedef struct packed {
    logic              wr_en;
    logic [PIDX_W-1:0] wr_idx;
    logic [7:0]        wr_data;
    logic [PCNT_W-1:0] flush_cnt;
    logic [1:0]        n_tail;
    tail_t             tail0;
    tail_t             tail1;
    logic              ovf;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FLUSH,
    B_TAIL
  } back_state_e;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
  endfunction

endpackage

// ===== rtl/core/tnorm_if.sv =====
interface tnorm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface tnorm_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       overflow;
  logic       run_last;

  modport source (output valid, output kind, output out_byte, output overflow,
                  output run_last, input ready);
  modport sink (input valid, input kind, input out_byte, input overflow,
                input run_last, output ready);
endinterface

interface tnorm_cfg_if;
  logic valid;
  logic ready;
  logic strip_punct;

  modport source (output valid, output strip_punct, input ready);
  modport sink (input valid, input strip_punct, output ready);
endinterface

// ===== rtl/core/tnorm_front.sv =====
module tnorm_front
  import tnorm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tnorm_in_if.sink   in_i,
  tnorm_cfg_if.sink  cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic              strip_q, strip_d;
  logic              ts_q, ts_d;
  logic              held_q, held_d;
  logic [PCNT_W-1:0] cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              accept;
  logic [7:0]        b;
  logic              is_close;
  logic              is_lat;
  tail_t             cur;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign b           = in_i.in_byte;
  assign is_close    = in_i.end_of_text || is_space(b);
  assign is_lat      = (b >= LAT_A) && (b <= LAT_Z);

  always_comb begin
    cur.kind = KIND_BYTE;
    cur.data = is_lat ? 8'(b + CASE_OFS) : b;
  end

  always_comb begin
    strip_d = cfg_i.valid ? cfg_i.strip_punct : strip_q;
    ts_d    = ts_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;

    cmd_o.wr_en      = 1'b0;
    cmd_o.wr_idx     = cnt_q[PIDX_W-1:0];
    cmd_o.wr_data    = b;
    cmd_o.flush_cnt  = '0;
    cmd_o.n_tail     = 2'd0;
    cmd_o.tail0      = '{kind: KIND_BYTE, data: LEAD_D0};
    cmd_o.tail1      = '{kind: KIND_MARK, data: 8'h00};
    cmd_o.ovf        = ovf_q;

    if (is_close) begin
      if (held_q) begin
        cmd_o.n_tail = 2'd2;
      end else if (ts_q) begin
        cmd_o.tail0  = '{kind: KIND_MARK, data: 8'h00};
        cmd_o.n_tail = 2'd1;
      end
      ts_d   = 1'b0;
      held_d = 1'b0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end else if (strip_q && is_punct(b)) begin
      if (held_q) begin
        cmd_o.n_tail = 2'd1;
        held_d       = 1'b0;
      end
      if (ts_q) begin
        if (cnt_q < PCNT_W'(PUNCT_DEPTH)) begin
          cmd_o.wr_en = 1'b1;
          cnt_d       = PCNT_W'(cnt_q + 1'b1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end else begin
      cmd_o.flush_cnt = cnt_q;
      cnt_d           = '0;
      ts_d            = 1'b1;
      held_d          = 1'b0;
      if (held_q) begin
        if (b >= CYR_LO && b < CYR_MID) begin
          cmd_o.tail1  = '{kind: KIND_BYTE, data: 8'(b + CASE_OFS)};
          cmd_o.n_tail = 2'd2;
        end else if (b >= CYR_MID && b <= CYR_HI) begin
          cmd_o.tail0  = '{kind: KIND_BYTE, data: LEAD_D1};
          cmd_o.tail1  = '{kind: KIND_BYTE, data: 8'(b - CASE_OFS)};
          cmd_o.n_tail = 2'd2;
        end else if (b == LEAD_D0) begin
          cmd_o.n_tail = 2'd1;
          held_d       = 1'b1;
        end else begin
          cmd_o.tail1  = cur;
          cmd_o.n_tail = 2'd2;
        end
      end else if (b == LEAD_D0) begin
        held_d = 1'b1;
      end else begin
        cmd_o.tail0  = cur;
        cmd_o.n_tail = 2'd1;
      end
    end
  end

  assign push_o = accept &&
                  (cmd_o.wr_en || (cmd_o.flush_cnt != '0) || (cmd_o.n_tail != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b1;
      ts_q    <= 1'b0;
      held_q  <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      strip_q <= strip_d;
      if (accept) begin
        ts_q   <= ts_d;
        held_q <= held_d;
        cnt_q  <= cnt_d;
        ovf_q  <= ovf_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_held_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> ts_q)
    else $error("lead byte held outside a started token");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PCNT_W'(PUNCT_DEPTH))
    else $error("punctuation count beyond buffer depth");
`endif

endmodule

// ===== rtl/core/tnorm_queue.sv =====
module tnorm_queue
  import tnorm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= (QPTR_W+1)'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= (QPTR_W+1)'(count_q - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/core/tnorm_back.sv =====
module tnorm_back
  import tnorm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  tnorm_out_if.source out_o
);

  back_state_e       state_q, state_d;
  logic [PCNT_W-1:0] idx_q, idx_d;
  logic              tsel_q, tsel_d;
  logic [7:0]        rd_data_q;
  logic [7:0]        pbuf_mem [PUNCT_DEPTH];
  logic              mem_we;
  logic              can_emit, emit;
  logic              emit_kind, emit_last;
  logic [7:0]        emit_byte;
  logic              last_flush;
  tail_t             sel_tail;
  logic              out_valid_q;
  logic              kind_q, ovf_q, last_q;
  logic [7:0]        byte_q;

  assign can_emit   = !out_valid_q || out_o.ready;
  assign last_flush = (idx_q == PCNT_W'(cmd_i.flush_cnt - 1'b1));
  assign sel_tail   = tsel_q ? cmd_i.tail1 : cmd_i.tail0;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    tsel_d    = tsel_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_BYTE;
    emit_byte = cmd_i.tail0.data;
    emit_last = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.flush_cnt != '0) begin
            state_d = B_FLUSH;
            idx_d   = '0;
          end else if (cmd_i.n_tail == 2'd0) begin
            pop_o  = 1'b1;
            mem_we = cmd_i.wr_en;
          end else if (can_emit) begin
            emit      = 1'b1;
            emit_kind = cmd_i.tail0.kind;
            emit_byte = cmd_i.tail0.data;
            emit_last = (cmd_i.n_tail == 2'd1);
            mem_we    = cmd_i.wr_en;
            if (cmd_i.n_tail == 2'd1) begin
              pop_o = 1'b1;
            end else begin
              state_d = B_TAIL;
              tsel_d  = 1'b1;
            end
          end
        end
      end
      B_FLUSH: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_kind = KIND_BYTE;
          emit_byte = rd_data_q;
          emit_last = last_flush && (cmd_i.n_tail == 2'd0);
          idx_d     = PCNT_W'(idx_q + 1'b1);
          if (last_flush) begin
            if (cmd_i.n_tail == 2'd0) begin
              pop_o   = 1'b1;
              state_d = B_IDLE;
            end else begin
              state_d = B_TAIL;
              tsel_d  = 1'b0;
            end
          end
        end
      end
      B_TAIL: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_kind = sel_tail.kind;
          emit_byte = sel_tail.data;
          emit_last = ({1'b0, tsel_q} == 2'(cmd_i.n_tail - 2'd1));
          if (emit_last) begin
            pop_o   = 1'b1;
            state_d = B_IDLE;
          end else begin
            tsel_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pbuf_mem[cmd_i.wr_idx] <= cmd_i.wr_data;
    end
    rd_data_q <= pbuf_mem[idx_d[PIDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      tsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      tsel_q  <= tsel_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= emit_kind;
      byte_q <= emit_byte;
      ovf_q  <= cmd_i.ovf;
      last_q <= emit_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = kind_q;
  assign out_o.out_byte = byte_q;
  assign out_o.overflow = ovf_q;
  assign out_o.run_last = last_q;

`ifndef SYNTHESIS
  a_flush_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_FLUSH) |-> (idx_q < cmd_i.flush_cnt) && !empty_i)
    else $error("flush index past buffered count");
`endif

endmodule

// ===== rtl/core/text_token_normalizer_unit.sv =====
// text token normalizer
// in_i: one text byte per transaction (in_byte, end_of_text); accepted when
//   valid and ready are both high. whitespace or end_of_text closes a word
// cfg_i: one-bit strip_punct write, always ready; the user writes it only while
//   the block idles, which the block itself does not enforce
// out_o: one normalized byte or end-of-token marker per transaction, with
//   overflow and run_last (set on the last result of an input byte)
// a front stage classifies each byte and queues a command when there is work;
// a back stage turns each command into 0 to 17 results through a one-entry
// output register. path: the queue entry, then the output register; a flush of
//   buffered punctuation first reads the punctuation memory into a register
// throughput: the back stage gives one result per cycle while the output is not
//   stalled, so a plain text byte sustains one per cycle. a 4-entry command
//   queue absorbs bursts, input ready drops while it is full
// reset: word state clears, strip_punct comes up set, queue and output empty
// a stalled receiver holds the output register; the back stage then stops and
// the queue fills before input ready drops
module text_token_normalizer_unit
  import tnorm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tnorm_in_if.sink    in_i,
  tnorm_cfg_if.sink   cfg_i,
  tnorm_out_if.source out_o
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t cmd_in, cmd_head;

  tnorm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (q_full),
    .push_o (q_push),
    .cmd_o  (cmd_in)
  );

  tnorm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (cmd_head)
  );

  tnorm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .cmd_i   (cmd_head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule
